[src/mbg_pkg.sv]
// Package for the maze backtracker generator: grid sizes, derived widths,
// the neighbour pick record and a small modulo-3 helper. No dependencies.
package mbg_pkg;

	// Built grid size
	localparam int GRID_WIDTH  = 16;
	localparam int GRID_HEIGHT = 16;

	// Derived sizes and widths
	localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
	localparam int XW         = $clog2(GRID_WIDTH);
	localparam int YW         = $clog2(GRID_HEIGHT);
	localparam int CW         = XW + YW;
	localparam int SAW        = $clog2(CELL_TOTAL);
	localparam int CNTW       = $clog2(CELL_TOTAL + 1);
	localparam int WSW        = $clog2(GRID_WIDTH + 1);
	localparam int HSW        = $clog2(GRID_HEIGHT + 1);
	localparam int CMPW       = ((XW > YW) ? XW : YW) + 2;

	// Fixed field widths
	localparam int SIZE_W  = 5;
	localparam int RND_W   = 8;
	localparam int COORD_W = 4;

	// Configuration register indexes
	localparam logic REG_MAZE_WIDTH  = 1'b0;
	localparam logic REG_MAZE_HEIGHT = 1'b1;

	// Neighbour directions, in search order
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	// Outcome of the neighbour search for one popped cell
	typedef struct packed {
		logic                  carved;
		logic [XW-1:0]         px;
		logic [YW-1:0]         py;
		logic [GRID_WIDTH-1:0] row_new;
	} pick_t;

	// v mod 3 via reciprocal multiply (171/512 ~ 1/3), exact for 8-bit v
	function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
		logic [2*RND_W-1:0] prod;
		logic [RND_W-1:0]   q;
		logic [RND_W-1:0]   rem;
		prod = v * 8'd171;
		q    = RND_W'(prod[2*RND_W-1:9]);
		rem  = v - RND_W'(q * 2'd3);
		return rem[1:0];
	endfunction

endpackage

[src/mbg_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/mbg_pick.sv]
// Neighbour search for one popped cell: bounds, visited test, count and
// random pick among up/down/left/right. Depends on mbg_pkg.
module mbg_pick import mbg_pkg::*; (
	input  logic [XW-1:0]         cx,
	input  logic [YW-1:0]         cy,
	input  logic [WSW-1:0]        used_w,
	input  logic [HSW-1:0]        used_h,
	input  logic [GRID_WIDTH-1:0] row_up,
	input  logic [GRID_WIDTH-1:0] row_mid,
	input  logic [GRID_WIDTH-1:0] row_dn,
	input  logic [RND_W-1:0]      rnd,
	output pick_t                 pick
);

	logic [CMPW-1:0] xe, ye, we_s, he_s;
	logic            ok_up, ok_dn, ok_lf, ok_rt;
	logic [XW-1:0]   xl, xr;
	logic [3:0]      avail;
	logic [2:0]      n;
	logic [1:0]      sel;
	logic [1:0]      seen;
	logic            found;
	dir_t            dir;

	// bounds against the sizes in use
	always_comb begin
		xe    = CMPW'(cx);
		ye    = CMPW'(cy);
		we_s  = CMPW'(used_w);
		he_s  = CMPW'(used_h);
		xl    = cx - XW'(1);
		xr    = cx + XW'(1);
		ok_up = (cy != '0) && (xe < we_s) && ((ye - CMPW'(1)) < he_s);
		ok_dn = (xe < we_s) && ((ye + CMPW'(1)) < he_s);
		ok_lf = (cx != '0) && ((xe - CMPW'(1)) < we_s) && (ye < he_s);
		ok_rt = ((xe + CMPW'(1)) < we_s) && (ye < he_s);
	end

	// unvisited candidates in search order
	assign avail[DIR_UP]    = ok_up & ~row_up[cx];
	assign avail[DIR_DOWN]  = ok_dn & ~row_dn[cx];
	assign avail[DIR_LEFT]  = ok_lf & ~row_mid[xl];
	assign avail[DIR_RIGHT] = ok_rt & ~row_mid[xr];

	assign n = 3'($countones(avail));

	// random value modulo candidate count
	always_comb begin
		unique case (n)
			3'd2:    sel = {1'b0, rnd[0]};
			3'd3:    sel = mod3(rnd);
			3'd4:    sel = rnd[1:0];
			default: sel = 2'd0;
		endcase
	end

	// walk to the sel-th candidate
	always_comb begin
		seen  = 2'd0;
		found = 1'b0;
		dir   = DIR_UP;
		for (int k = 0; k < 4; k++) begin
			if (avail[k] && !found) begin
				if (seen == sel) begin
					found = 1'b1;
					dir   = dir_t'(k);
				end else begin
					seen = seen + 2'd1;
				end
			end
		end
	end

	// neighbour coordinates and its updated visited row
	always_comb begin
		pick.carved = (n != 3'd0);
		unique case (dir)
			DIR_UP: begin
				pick.px      = cx;
				pick.py      = cy - YW'(1);
				pick.row_new = row_up;
			end
			DIR_DOWN: begin
				pick.px      = cx;
				pick.py      = cy + YW'(1);
				pick.row_new = row_dn;
			end
			DIR_LEFT: begin
				pick.px      = xl;
				pick.py      = cy;
				pick.row_new = row_mid;
			end
			default: begin
				pick.px      = xr;
				pick.py      = cy;
				pick.row_new = row_mid;
			end
		endcase
		pick.row_new[pick.px] = 1'b1;
	end

endmodule

[src/maze_backtracker_generator.sv]
// Top level of the maze backtracker generator: control sequencer, cell stack
// and visited-row memories. Depends on mbg_pkg, mbg_ram and mbg_pick.
//
// Depth-first maze carver. The cell stack sits in one RAM (one cell per
// entry) and the visited map in a second RAM holding one grid row per word.
// One item is handled at a time; in_ready is high only between items. A step
// on a non-empty stack that carves runs the pop read, three visited-row reads
// on the single read port, pick, two pushes through the single stack write
// port and the result; one that only pops skips the pushes, and a step on an
// empty stack goes straight to the result. A restart sweeps the visited RAM
// one row per cycle. The map needs no sweep after reset: it is only read after
// a restart. A finished result waits in the output register while the next
// beat is accepted.
module maze_backtracker_generator import mbg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SIZE_W-1:0]   cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                restart,
	input  logic [RND_W-1:0]    random_value,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                carved,
	output logic [COORD_W-1:0]  from_x,
	output logic [COORD_W-1:0]  from_y,
	output logic [COORD_W-1:0]  to_x,
	output logic [COORD_W-1:0]  to_y,
	output logic                done_res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ROWM,
		ST_ROWU,
		ST_ROWD,
		ST_PICK,
		ST_PUSH0,
		ST_PUSH1,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNTW-1:0]     cnt_q;
	logic [YW-1:0]       clr_row_q;
	logic [RND_W-1:0]    rnd_q;
	logic                popped_q;
	logic [XW-1:0]       cx_q;
	logic [YW-1:0]       cy_q;
	logic [GRID_WIDTH-1:0] row_mid_q, row_up_q;
	pick_t               pick_q;
	pick_t               pick;
	logic [SIZE_W-1:0]   maze_width_q, maze_height_q;
	logic [WSW-1:0]      used_w;
	logic [HSW-1:0]      used_h;

	logic                out_valid_q, carved_q, done_q;
	logic [COORD_W-1:0]  from_x_q, from_y_q, to_x_q, to_y_q;

	// memory ports
	logic                stk_we, stk_re;
	logic [SAW-1:0]      stk_waddr, stk_raddr;
	logic [CW-1:0]       stk_wdata, stk_rdata;
	logic                map_we, map_re;
	logic [YW-1:0]       map_waddr, map_raddr;
	logic [GRID_WIDTH-1:0] map_wdata, map_rdata;

	logic                in_beat, out_free, push_ok;
	logic [CNTW-1:0]     cnt_dec;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign cnt_dec  = cnt_q - CNTW'(1);
	assign push_ok  = (cnt_q < CNTW'(CELL_TOTAL));

	// sizes in use: zero reads as one, oversize saturates to the built grid
	always_comb begin
		if (maze_width_q == '0) begin
			used_w = WSW'(1);
		end else if (int'(maze_width_q) > GRID_WIDTH) begin
			used_w = WSW'(GRID_WIDTH);
		end else begin
			used_w = WSW'(maze_width_q);
		end
		if (maze_height_q == '0) begin
			used_h = HSW'(1);
		end else if (int'(maze_height_q) > GRID_HEIGHT) begin
			used_h = HSW'(GRID_HEIGHT);
		end else begin
			used_h = HSW'(maze_height_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_width_q  <= SIZE_W'(16);
			maze_height_q <= SIZE_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAZE_WIDTH:  maze_width_q  <= cfg_data;
				REG_MAZE_HEIGHT: maze_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stack port control
	always_comb begin
		stk_re    = in_beat & ~restart & (cnt_q != '0);
		stk_raddr = SAW'(cnt_dec);
		stk_we    = 1'b0;
		stk_waddr = SAW'(cnt_q);
		stk_wdata = {cy_q, cx_q};
		unique case (state_q)
			ST_CLEAR: begin
				stk_we    = (clr_row_q == '0);
				stk_waddr = '0;
				stk_wdata = '0;
			end
			ST_PUSH0: stk_we = push_ok;
			ST_PUSH1: begin
				stk_we    = push_ok;
				stk_wdata = {pick_q.py, pick_q.px};
			end
			default: ;
		endcase
	end

	// visited-row port control
	always_comb begin
		map_re    = 1'b0;
		map_raddr = cy_q;
		map_we    = 1'b0;
		map_waddr = pick_q.py;
		map_wdata = pick_q.row_new;
		unique case (state_q)
			ST_ROWM: begin
				map_re    = 1'b1;
				map_raddr = stk_rdata[CW-1:XW];
			end
			ST_ROWU: begin
				map_re    = 1'b1;
				map_raddr = (cy_q != '0) ? cy_q - YW'(1) : cy_q;
			end
			ST_ROWD: begin
				map_re    = 1'b1;
				map_raddr = (int'(cy_q) < GRID_HEIGHT - 1) ? cy_q + YW'(1) : cy_q;
			end
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_row_q;
				map_wdata = (clr_row_q == '0) ? GRID_WIDTH'(1) : '0;
			end
			ST_PUSH0: map_we = 1'b1;
			default: ;
		endcase
	end

	mbg_ram #(.WIDTH(CW), .DEPTH(CELL_TOTAL)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	mbg_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_visited (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// down row comes straight from the read port in ST_PICK
	mbg_pick u_pick (
		.cx      (cx_q),
		.cy      (cy_q),
		.used_w  (used_w),
		.used_h  (used_h),
		.row_up  (row_up_q),
		.row_mid (row_mid_q),
		.row_dn  (map_rdata),
		.rnd     (rnd_q),
		.pick    (pick)
	);

	// sequencer, stack count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			clr_row_q   <= '0;
			rnd_q       <= '0;
			popped_q    <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			row_mid_q   <= '0;
			row_up_q    <= '0;
			pick_q      <= '0;
			out_valid_q <= 1'b0;
			carved_q    <= 1'b0;
			done_q      <= 1'b0;
			from_x_q    <= '0;
			from_y_q    <= '0;
			to_x_q      <= '0;
			to_y_q      <= '0;
		end else begin
			// a beat leaves the output register; ST_OUT refills it itself
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						rnd_q    <= random_value;
						popped_q <= 1'b0;
						if (restart) begin
							cnt_q     <= CNTW'(1);
							clr_row_q <= '0;
							state_q   <= ST_CLEAR;
						end else if (cnt_q != '0) begin
							cnt_q    <= cnt_dec;
							popped_q <= 1'b1;
							state_q  <= ST_ROWM;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + YW'(1);
					if (int'(clr_row_q) == GRID_HEIGHT - 1) begin
						state_q <= ST_OUT;
					end
				end
				ST_ROWM: begin
					cx_q    <= stk_rdata[XW-1:0];
					cy_q    <= stk_rdata[CW-1:XW];
					state_q <= ST_ROWU;
				end
				ST_ROWU: begin
					row_mid_q <= map_rdata;
					state_q   <= ST_ROWD;
				end
				ST_ROWD: begin
					row_up_q <= map_rdata;
					state_q  <= ST_PICK;
				end
				ST_PICK: begin
					pick_q  <= pick;
					state_q <= pick.carved ? ST_PUSH0 : ST_OUT;
				end
				ST_PUSH0: begin
					if (push_ok) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
					state_q <= ST_PUSH1;
				end
				ST_PUSH1: begin
					if (push_ok) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						carved_q    <= popped_q & pick_q.carved;
						from_x_q    <= popped_q ? COORD_W'(cx_q) : '0;
						from_y_q    <= popped_q ? COORD_W'(cy_q) : '0;
						to_x_q      <= (popped_q & pick_q.carved) ? COORD_W'(pick_q.px) : '0;
						to_y_q      <= (popped_q & pick_q.carved) ? COORD_W'(pick_q.py) : '0;
						done_q      <= (cnt_q == '0);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign carved    = carved_q;
	assign from_x    = from_x_q;
	assign from_y    = from_y_q;
	assign to_x      = to_x_q;
	assign to_y      = to_y_q;
	assign done_res  = done_q;

	// stack never grows past the grid
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CELL_TOTAL))
		else $error("stack count above cell total");

	// a carved passage joins two adjacent cells
	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carved |->
			((from_x == to_x) &&
			 ((to_y == from_y + 4'd1) || (from_y == to_y + 4'd1))) ||
			((from_y == to_y) &&
			 ((to_x == from_x + 4'd1) || (from_x == to_x + 4'd1))))
		else $error("carved passage between non-adjacent cells");

	// a carving step leaves at least two cells on the stack
	a_carve_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carved |-> !done_res)
		else $error("done flagged on a carving step");

	// one item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");

	// memory writes only happen outside the read phase of a step
	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		map_re |-> !map_we && !stk_we)
		else $error("visited read overlaps a write");

endmodule
